// ===== src/sct_pkg.sv =====
package sct_pkg;

    localparam int KW_TABLE = 33;
    localparam int KW_WIDTH = 15;

    typedef logic [20:0] t_cp;

    // Lexer modes
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUMBER   = 4'd2;
    localparam logic [3:0] M_NUMDOT   = 4'd3;
    localparam logic [3:0] M_FRACTION = 4'd4;
    localparam logic [3:0] M_STRING   = 4'd5;
    localparam logic [3:0] M_ESCAPE   = 4'd6;
    localparam logic [3:0] M_PENDOP   = 4'd7;
    localparam logic [3:0] M_COMMENT  = 4'd8;

    // Pending operator codes
    localparam logic [2:0] P_NONE  = 3'd0;
    localparam logic [2:0] P_MINUS = 3'd1;
    localparam logic [2:0] P_ASSIGN = 3'd2;
    localparam logic [2:0] P_BANG  = 3'd3;
    localparam logic [2:0] P_LT    = 3'd4;
    localparam logic [2:0] P_GT    = 3'd5;
    localparam logic [2:0] P_SLASH = 3'd6;

    // Record types
    localparam logic [1:0] R_TEXT  = 2'd0;
    localparam logic [1:0] R_TOKEN = 2'd1;
    localparam logic [1:0] R_ERROR = 2'd2;

    // Token kinds
    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_INT     = 6'd2;
    localparam logic [5:0] K_DECIMAL = 6'd3;
    localparam logic [5:0] K_STRING  = 6'd4;
    localparam logic [5:0] K_KW0     = 6'd5;
    localparam logic [5:0] K_DOT     = 6'd45;
    localparam logic [5:0] K_SLASH   = 6'd51;
    localparam logic [5:0] K_MINUS   = 6'd52;
    localparam logic [5:0] K_ARROW   = 6'd53;
    localparam logic [5:0] K_ASSIGN  = 6'd54;
    localparam logic [5:0] K_EQ      = 6'd55;
    localparam logic [5:0] K_NE      = 6'd56;
    localparam logic [5:0] K_LT      = 6'd57;
    localparam logic [5:0] K_LE      = 6'd58;
    localparam logic [5:0] K_GT      = 6'd59;
    localparam logic [5:0] K_GE      = 6'd60;

    // Error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNCLOSED = 3'd1;
    localparam logic [2:0] E_BANG     = 3'd2;
    localparam logic [2:0] E_UNEXP    = 3'd3;
    localparam logic [2:0] E_OVERFLOW = 3'd4;

    localparam logic [62:0] ACC_MAX = {63{1'b1}};

    // Keyword lengths and letters, letters as offsets from U+0430
    localparam logic [3:0] KW_LEN [KW_TABLE] = '{
        4'd9, 4'd7, 4'd5, 4'd7, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd5,
        4'd4, 4'd5, 4'd4, 4'd3, 4'd8, 4'd10, 4'd7, 4'd7, 4'd5, 4'd9, 4'd14,
        4'd7, 4'd5, 4'd4, 4'd7, 4'd8, 4'd7, 4'd7, 4'd6, 4'd4, 4'd6, 4'd4};

    typedef logic [4:0] t_kw_row [KW_WIDTH];

    localparam t_kw_row KW_CHR [KW_TABLE] = '{
        '{10,14,13,17,18,0,13,18,0,0,0,0,0,0,0},
        '{17,18,16,14,3,14,5,0,0,0,0,0,0,0,0},
        '{22,5,11,14,5,0,0,0,0,0,0,0,0,0,0},
        '{4,16,14,1,13,14,5,0,0,0,0,0,0,0,0},
        '{17,11,14,2,14,0,0,0,0,0,0,0,0,0,0},
        '{17,18,16,14,10,0,0,0,0,0,0,0,0,0,0},
        '{1,19,11,5,2,14,0,0,0,0,0,0,0,0,0},
        '{17,15,8,17,14,10,0,0,0,0,0,0,0,0,0},
        '{17,11,14,2,0,16,28,0,0,0,0,0,0,0,0},
        '{10,14,16,18,5,6,0,0,0,0,0,0,0,0,0},
        '{13,8,23,18,14,0,0,0,0,0,0,0,0,0,0},
        '{5,17,11,8,0,0,0,0,0,0,0,0,0,0,0},
        '{8,13,0,23,5,0,0,0,0,0,0,0,0,0,0},
        '{15,14,10,0,0,0,0,0,0,0,0,0,0,0,0},
        '{4,11,31,0,0,0,0,0,0,0,0,0,0,0,0},
        '{15,16,5,16,2,0,18,28,0,0,0,0,0,0,0},
        '{15,16,14,4,14,11,6,8,18,28,0,0,0,0,0},
        '{2,14,7,2,16,0,18,0,0,0,0,0,0,0,0},
        '{20,19,13,10,22,8,31,0,0,0,0,0,0,0,0},
        '{10,11,0,17,17,0,0,0,0,0,0,0,0,0,0},
        '{13,0,17,11,5,4,19,5,18,0,0,0,0,0,0},
        '{15,5,16,5,14,15,16,5,4,5,11,8,18,28,0},
        '{1,0,7,14,2,27,9,0,0,0,0,0,0,0,0},
        '{13,14,2,27,9,0,0,0,0,0,0,0,0,0,0},
        '{17,5,1,31,0,0,0,0,0,0,0,0,0,0,0},
        '{15,14,15,27,18,10,0,0,0,0,0,0,0,0,0},
        '{15,5,16,5,21,2,0,18,0,0,0,0,0,0,0},
        '{13,0,10,14,13,5,22,0,0,0,0,0,0,0,0},
        '{15,14,4,13,31,18,28,0,0,0,0,0,0,0,0},
        '{15,5,23,0,18,28,0,0,0,0,0,0,0,0,0},
        '{2,2,14,4,0,0,0,0,0,0,0,0,0,0,0},
        '{8,17,18,8,13,0,0,0,0,0,0,0,0,0,0},
        '{11,14,6,28,0,0,0,0,0,0,0,0,0,0,0}};

    function automatic logic f_ident_start(input t_cp c);
        return c == 21'h5F || (c >= 21'h61 && c <= 21'h7A) ||
               (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h400 && c <= 21'h4FF);
    endfunction

    function automatic logic f_digit(input t_cp c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic f_blank(input t_cp c);
        return c == 21'h20 || c == 21'h09 || c == 21'h0D || c == 21'h0A;
    endfunction

    function automatic logic [5:0] f_single_op(input t_cp c);
        logic [5:0] k;
        k = 6'd0;
        case (c)
            21'h28: k = 6'd38;
            21'h29: k = 6'd39;
            21'h7B: k = 6'd40;
            21'h7D: k = 6'd41;
            21'h5B: k = 6'd42;
            21'h5D: k = 6'd43;
            21'h2C: k = 6'd44;
            21'h2E: k = 6'd45;
            21'h3A: k = 6'd46;
            21'h3B: k = 6'd47;
            21'h2B: k = 6'd48;
            21'h2A: k = 6'd49;
            21'h25: k = 6'd50;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] f_pending(input t_cp c);
        logic [2:0] p;
        p = P_NONE;
        case (c)
            21'h2D: p = P_MINUS;
            21'h3D: p = P_ASSIGN;
            21'h21: p = P_BANG;
            21'h3C: p = P_LT;
            21'h3E: p = P_GT;
            21'h2F: p = P_SLASH;
            default: p = P_NONE;
        endcase
        return p;
    endfunction

endpackage

// ===== src/source_code_tokenizer.sv =====
// Streaming tokenizer: takes one code point per beat (0 ends the source) and gives up to three
// records per input beat (text, token, error), the last one marked by o_last_of_run. The whole
// step is one pass of combinational logic from the input port into the lexer state and a
// three-slot result buffer. A beat is taken in any cycle in which that buffer is empty or is
// handing out its last record, so an item that gives n records holds the input until the last
// of them is taken, and items that give at most one record each go through back to back while
// i_ready stays high. Keyword match is a parallel mask narrowed per letter.
module source_code_tokenizer #(
    parameter int KEYWORD_COUNT      = 33,
    parameter int MAX_KEYWORD_LENGTH = 14,
    parameter int LINE_BITS          = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [20:0]            i_code_point,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_record_type,
    output logic [5:0]             o_token_kind,
    output logic [20:0]            o_text_char,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [15:0]            o_token_column,
    output logic [62:0]            o_number_digits,
    output logic [4:0]             o_fraction_digits,
    output logic [2:0]             o_error_code,
    output logic                   o_last_of_run
);
    import sct_pkg::*;

    localparam int KWN = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
    localparam logic [3:0] MAXKW = 4'(MAX_KEYWORD_LENGTH);

    typedef struct packed {
        logic [1:0]           rtype;
        logic [5:0]           kind;
        logic [20:0]          text;
        logic [LINE_BITS-1:0] line;
        logic [15:0]          col;
        logic [62:0]          digits;
        logic [4:0]           frac;
        logic [2:0]           err;
    } t_rec;

    // Lexer state
    logic [3:0]               r_mode, n_mode;
    logic [2:0]               r_pend, n_pend;
    logic [KEYWORD_COUNT-1:0] r_mask, n_mask;
    logic [3:0]               r_ilen, n_ilen;
    logic [62:0]              r_acc, n_acc;
    logic [4:0]               r_frac, n_frac;
    logic [LINE_BITS-1:0]     r_sline, n_sline, r_cline, n_cline;
    logic [15:0]              r_scol, n_scol, r_ccol, n_ccol, r_dcol, n_dcol;
    logic                     r_err, n_err;

    // Result buffer
    t_rec       r_rec [3];
    t_rec       n_rec [3];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_pos;

    logic accept;
    t_cp  c;
    assign c = i_code_point;
    assign o_ready = (r_cnt == 2'd0) || (r_cnt == r_pos + 2'd1 && i_ready);
    assign accept = i_valid && o_ready;

    // Lexer step: at most two passes (token close, then the same character again)
    always_comb begin
        logic [KEYWORD_COUNT-1:0] mk;
        logic [3:0]   md;
        logic [2:0]   pd;
        logic         again, wrst, ovf, frc, dig;
        logic [3:0]   d;
        logic [62:0]  acc10;
        logic [66:0]  prod;
        logic [5:0]   kind, sop;
        int           pass;
        logic [1:0]   cnt;
        t_rec         z;

        z = '0;
        n_rec = '{default: z};
        cnt = 2'd0;
        n_mode = r_mode; n_pend = r_pend; n_mask = r_mask; n_ilen = r_ilen;
        n_acc = r_acc; n_frac = r_frac; n_sline = r_sline; n_scol = r_scol;
        n_cline = r_cline; n_ccol = r_ccol; n_dcol = r_dcol; n_err = r_err;
        wrst = 1'b0;
        again = 1'b1;
        d = c[3:0];
        prod = {4'd0, r_acc} * 67'd10 + {63'd0, d};
        acc10 = prod[62:0];
        ovf = prod > {4'd0, ACC_MAX};
        kind = K_IDENT;
        mk = '0;
        md = M_IDLE; pd = P_NONE; frc = 1'b0; dig = f_digit(c); sop = f_single_op(c);

        for (pass = 0; pass < 2; pass++) begin
            if (again) begin
                again = 1'b0;
                if (n_err) begin
                    if (c == 21'd0) wrst = 1'b1;
                end else begin
                    md = n_mode;
                    unique case (md)
                        M_IDLE: begin
                            if (c == 21'd0) begin
                                n_rec[cnt] = '{R_TOKEN, K_END, 21'd0, n_cline, n_ccol,
                                               63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                                wrst = 1'b1;
                            end else if (!f_blank(c)) begin
                                n_sline = n_cline; n_scol = n_ccol;
                                if (f_ident_start(c)) begin
                                    n_mode = M_IDENT;
                                    n_ilen = 4'd0;
                                    n_mask = '1;
                                end else if (dig) begin
                                    n_acc = {59'd0, d}; n_frac = 5'd0; n_mode = M_NUMBER;
                                end else if (c == 21'h22) begin
                                    n_mode = M_STRING;
                                end else if (sop != 6'd0) begin
                                    n_rec[cnt] = '{R_TOKEN, sop, 21'd0, n_cline, n_ccol,
                                                   63'd0, 5'd0, E_NONE};
                                    cnt = cnt + 2'd1;
                                end else if (f_pending(c) != P_NONE) begin
                                    n_pend = f_pending(c); n_mode = M_PENDOP;
                                end else begin
                                    n_rec[cnt] = '{R_ERROR, K_END, 21'd0, n_cline, n_ccol,
                                                   63'd0, 5'd0, E_UNEXP};
                                    cnt = cnt + 2'd1;
                                    n_err = 1'b1;
                                end
                            end
                        end
                        M_IDENT: begin
                            if (!(f_ident_start(c) || dig)) begin
                                kind = K_IDENT;
                                if (r_ilen <= MAXKW) begin
                                    for (int k = KWN - 1; k >= 0; k--) begin
                                        if (r_mask[k] && KW_LEN[k] == r_ilen)
                                            kind = K_KW0 + 6'(k);
                                    end
                                end
                                n_rec[cnt] = '{R_TOKEN, kind, 21'd0, r_sline, r_scol,
                                               63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                                n_mode = M_IDLE;
                                again = 1'b1;
                            end
                        end
                        M_NUMBER, M_NUMDOT, M_FRACTION: begin
                            if (dig) begin
                                frc = md != M_NUMBER;
                                if (ovf || (frc && r_frac >= 5'd19)) begin
                                    n_rec[cnt] = '{R_ERROR, K_END, 21'd0, r_sline, r_scol,
                                                   63'd0, 5'd0, E_OVERFLOW};
                                    cnt = cnt + 2'd1;
                                    n_err = 1'b1;
                                    n_mode = M_IDLE;
                                end else begin
                                    n_acc = acc10;
                                    if (frc) n_frac = r_frac + 5'd1;
                                    if (md == M_NUMDOT) n_mode = M_FRACTION;
                                end
                            end else if (md == M_NUMBER && c == 21'h2E) begin
                                n_dcol = r_ccol; n_mode = M_NUMDOT;
                            end else begin
                                n_rec[cnt] = '{R_TOKEN, (md == M_FRACTION) ? K_DECIMAL : K_INT,
                                               21'd0, r_sline, r_scol, r_acc,
                                               (md == M_FRACTION) ? r_frac : 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                                if (md == M_NUMDOT) begin
                                    n_rec[cnt] = '{R_TOKEN, K_DOT, 21'd0, r_cline, r_dcol,
                                                   63'd0, 5'd0, E_NONE};
                                    cnt = cnt + 2'd1;
                                end
                                n_mode = M_IDLE;
                                again = 1'b1;
                            end
                        end
                        M_STRING, M_ESCAPE: begin
                            if (c == 21'd0) begin
                                n_rec[cnt] = '{R_ERROR, K_END, 21'd0, r_sline, r_scol,
                                               63'd0, 5'd0, E_UNCLOSED};
                                cnt = cnt + 2'd1;
                                wrst = 1'b1;
                            end else if (md == M_ESCAPE) begin
                                n_rec[cnt] = '{R_TEXT, K_END,
                                               (c == 21'h6E) ? 21'd10 :
                                               ((c == 21'h74) ? 21'd9 : c),
                                               r_sline, r_scol, 63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                                n_mode = M_STRING;
                            end else if (c == 21'h22) begin
                                n_rec[cnt] = '{R_TOKEN, K_STRING, 21'd0, r_sline, r_scol,
                                               63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                                n_mode = M_IDLE;
                            end else if (c == 21'h5C) begin
                                n_mode = M_ESCAPE;
                            end else begin
                                n_rec[cnt] = '{R_TEXT, K_END, c, r_sline, r_scol,
                                               63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                            end
                        end
                        M_PENDOP: begin
                            pd = r_pend;
                            n_pend = P_NONE; n_mode = M_IDLE;
                            again = 1'b1;
                            kind = K_END;
                            case (pd)
                                P_SLASH: begin
                                    if (c == 21'h2F) begin
                                        n_mode = M_COMMENT; again = 1'b0;
                                    end else kind = K_SLASH;
                                end
                                P_MINUS: begin
                                    if (c == 21'h3E) begin
                                        kind = K_ARROW; again = 1'b0;
                                    end else kind = K_MINUS;
                                end
                                P_BANG: begin
                                    if (c == 21'h3D) begin
                                        kind = K_NE; again = 1'b0;
                                    end else begin
                                        n_rec[cnt] = '{R_ERROR, K_END, 21'd0, r_sline, r_scol,
                                                       63'd0, 5'd0, E_BANG};
                                        cnt = cnt + 2'd1;
                                        n_err = 1'b1;
                                    end
                                end
                                P_ASSIGN, P_LT, P_GT: begin
                                    kind = (pd == P_ASSIGN) ? K_ASSIGN :
                                           ((pd == P_LT) ? K_LT : K_GT);
                                    if (c == 21'h3D) begin
                                        kind = kind + 6'd1; again = 1'b0;
                                    end
                                end
                                default: kind = K_END;
                            endcase
                            if (kind != K_END) begin
                                n_rec[cnt] = '{R_TOKEN, kind, 21'd0, r_sline, r_scol,
                                               63'd0, 5'd0, E_NONE};
                                cnt = cnt + 2'd1;
                            end
                        end
                        M_COMMENT: begin
                            if (c == 21'h0A) n_mode = M_IDLE;
                            else if (c == 21'd0) begin
                                n_mode = M_IDLE; again = 1'b1;
                            end
                        end
                        default: begin
                            n_mode = M_IDLE; again = 1'b1;
                        end
                    endcase
                end
            end
        end

        // Identifier character: narrow keyword mask and emit text (runs after any re-entry)
        if (!n_err && !wrst && n_mode == M_IDENT) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                mk[k] = 1'b0;
                if (k < KWN) begin
                    mk[k] = n_ilen < KW_LEN[k] && n_ilen < MAXKW && n_ilen < 4'(KW_WIDTH) &&
                            c == 21'h430 + {16'd0, KW_CHR[k][n_ilen]};
                end
            end
            n_mask = n_mask & mk;
            if (n_ilen < 4'd15) n_ilen = n_ilen + 4'd1;
            n_rec[cnt] = '{R_TEXT, K_END, c, n_sline, n_scol, 63'd0, 5'd0, E_NONE};
            cnt = cnt + 2'd1;
        end

        if (wrst) begin
            n_mode = M_IDLE; n_pend = P_NONE; n_ilen = 4'd0; n_frac = 5'd0;
            n_mask = '1; n_acc = '0; n_sline = LINE_ONE; n_cline = LINE_ONE;
            n_scol = 16'd1; n_ccol = 16'd1; n_dcol = 16'd1; n_err = 1'b0;
        end else if (c != 21'd0) begin
            if (c == 21'h0A) begin
                if (n_cline < LINE_MAX) n_cline = n_cline + LINE_ONE;
                n_ccol = 16'd1;
            end else if (n_ccol != 16'hFFFF) begin
                n_ccol = n_ccol + 16'd1;
            end
        end
        n_cnt = cnt;
    end

    // Advance state on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pend <= P_NONE; r_mask <= '1; r_ilen <= 4'd0;
            r_acc <= '0; r_frac <= 5'd0; r_sline <= LINE_ONE; r_scol <= 16'd1;
            r_cline <= LINE_ONE; r_ccol <= 16'd1; r_dcol <= 16'd1; r_err <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode; r_pend <= n_pend; r_mask <= n_mask; r_ilen <= n_ilen;
            r_acc <= n_acc; r_frac <= n_frac; r_sline <= n_sline; r_scol <= n_scol;
            r_cline <= n_cline; r_ccol <= n_ccol; r_dcol <= n_dcol; r_err <= n_err;
        end
    end

    // Result buffer: load on accept, drain one record per output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_pos <= 2'd0;
        end else if (o_valid && i_ready) begin
            if (r_pos + 2'd1 == r_cnt) begin
                r_cnt <= 2'd0;
                r_pos <= 2'd0;
            end else r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_rec <= n_rec;
    end

    assign o_valid           = r_cnt != 2'd0;
    assign o_record_type     = r_rec[r_pos].rtype;
    assign o_token_kind      = r_rec[r_pos].kind;
    assign o_text_char       = r_rec[r_pos].text;
    assign o_token_line      = r_rec[r_pos].line;
    assign o_token_column    = r_rec[r_pos].col;
    assign o_number_digits   = r_rec[r_pos].digits;
    assign o_fraction_digits = r_rec[r_pos].frac;
    assign o_error_code      = r_rec[r_pos].err;
    assign o_last_of_run     = r_pos + 2'd1 == r_cnt;

    // Checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pos < r_cnt) else $error("read slot beyond record count");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && o_valid |-> o_last_of_run && i_ready) else $error("records overwritten");
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_mode == M_IDLE) else $error("error latched outside idle");
    a_col_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccol != 16'd0 && r_cline != '0) else $error("position dropped to zero");
endmodule
